@@ rtl/c65_pkg.sv @@
package c65_pkg;

	// Command codes of the input item
	localparam logic [4:0] CMD_ORA = 5'd0;
	localparam logic [4:0] CMD_AND = 5'd1;
	localparam logic [4:0] CMD_EOR = 5'd2;
	localparam logic [4:0] CMD_BIT = 5'd3;
	localparam logic [4:0] CMD_ASL = 5'd4;
	localparam logic [4:0] CMD_LSR = 5'd5;
	localparam logic [4:0] CMD_ROL = 5'd6;
	localparam logic [4:0] CMD_ROR = 5'd7;
	localparam logic [4:0] CMD_ADC = 5'd8;
	localparam logic [4:0] CMD_SBC = 5'd9;
	localparam logic [4:0] CMD_CMP = 5'd10;
	localparam logic [4:0] CMD_CPX = 5'd11;
	localparam logic [4:0] CMD_CPY = 5'd12;
	localparam logic [4:0] CMD_LDA = 5'd13;
	localparam logic [4:0] CMD_LDX = 5'd14;
	localparam logic [4:0] CMD_LDY = 5'd15;
	localparam logic [4:0] CMD_STA = 5'd16;
	localparam logic [4:0] CMD_STX = 5'd17;
	localparam logic [4:0] CMD_STY = 5'd18;
	localparam logic [4:0] CMD_TAX = 5'd19;
	localparam logic [4:0] CMD_TAY = 5'd20;
	localparam logic [4:0] CMD_TSX = 5'd21;
	localparam logic [4:0] CMD_TXA = 5'd22;
	localparam logic [4:0] CMD_TXS = 5'd23;
	localparam logic [4:0] CMD_TYA = 5'd24;
	localparam logic [4:0] CMD_INC = 5'd25;
	localparam logic [4:0] CMD_DEC = 5'd26;
	localparam logic [4:0] CMD_INX = 5'd27;
	localparam logic [4:0] CMD_INY = 5'd28;
	localparam logic [4:0] CMD_DEX = 5'd29;
	localparam logic [4:0] CMD_DEY = 5'd30;

	// Operation classes handed from front to back
	localparam logic [3:0] CLS_NOP   = 4'd0;
	localparam logic [3:0] CLS_LOGIC = 4'd1;
	localparam logic [3:0] CLS_BIT   = 4'd2;
	localparam logic [3:0] CLS_SHIFT = 4'd3;
	localparam logic [3:0] CLS_ADD   = 4'd4;
	localparam logic [3:0] CLS_CMP   = 4'd5;
	localparam logic [3:0] CLS_LOAD  = 4'd6;
	localparam logic [3:0] CLS_STORE = 4'd7;
	localparam logic [3:0] CLS_XFER  = 4'd8;
	localparam logic [3:0] CLS_STEPM = 4'd9;
	localparam logic [3:0] CLS_STEPR = 4'd10;

	// Register selects
	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_X = 2'd1;
	localparam logic [1:0] REG_Y = 2'd2;
	localparam logic [1:0] REG_S = 2'd3;

	// Sub-functions
	localparam logic [1:0] FN_OR  = 2'd0;
	localparam logic [1:0] FN_AND = 2'd1;
	localparam logic [1:0] FN_EOR = 2'd2;
	localparam logic [1:0] FN_ASL = 2'd0;
	localparam logic [1:0] FN_LSR = 2'd1;
	localparam logic [1:0] FN_ROL = 2'd2;
	localparam logic [1:0] FN_ROR = 2'd3;
	localparam logic [1:0] FN_INC = 2'd0;
	localparam logic [1:0] FN_DEC = 2'd1;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SP_RESET = 8'hFD;

	typedef struct packed {
		logic [4:0] command;
		logic [7:0] operand;
		logic       target_is_accumulator;
	} in_item_t;

	typedef struct packed {
		logic [7:0] write_value;
		logic       write_enable;
		logic [7:0] acc_value;
		logic [7:0] x_value;
		logic [7:0] y_value;
		logic [7:0] stack_value;
		logic [3:0] flags_nvzc;
	} out_item_t;

	typedef struct packed {
		logic [3:0] cls;
		logic [1:0] fn;
		logic [1:0] src_reg;
		logic [1:0] dst_reg;
		logic [7:0] operand;
		logic       to_acc;
	} dec_op_t;

endpackage

@@ rtl/c65_front.sv @@
module c65_front (
	input  c65_pkg::in_item_t in_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              queue_full,
	output logic              push_valid,
	output c65_pkg::dec_op_t  push_op
);

	assign in_ready   = !queue_full;
	assign push_valid = in_valid && !queue_full;

	always_comb begin
		push_op         = '0;
		push_op.cls     = c65_pkg::CLS_NOP;
		push_op.operand = in_data.operand;
		push_op.to_acc  = in_data.target_is_accumulator;
		unique case (in_data.command)
			c65_pkg::CMD_ORA: begin
				push_op.cls = c65_pkg::CLS_LOGIC;
				push_op.fn  = c65_pkg::FN_OR;
			end
			c65_pkg::CMD_AND: begin
				push_op.cls = c65_pkg::CLS_LOGIC;
				push_op.fn  = c65_pkg::FN_AND;
			end
			c65_pkg::CMD_EOR: begin
				push_op.cls = c65_pkg::CLS_LOGIC;
				push_op.fn  = c65_pkg::FN_EOR;
			end
			c65_pkg::CMD_BIT: push_op.cls = c65_pkg::CLS_BIT;
			c65_pkg::CMD_ASL: begin
				push_op.cls = c65_pkg::CLS_SHIFT;
				push_op.fn  = c65_pkg::FN_ASL;
			end
			c65_pkg::CMD_LSR: begin
				push_op.cls = c65_pkg::CLS_SHIFT;
				push_op.fn  = c65_pkg::FN_LSR;
			end
			c65_pkg::CMD_ROL: begin
				push_op.cls = c65_pkg::CLS_SHIFT;
				push_op.fn  = c65_pkg::FN_ROL;
			end
			c65_pkg::CMD_ROR: begin
				push_op.cls = c65_pkg::CLS_SHIFT;
				push_op.fn  = c65_pkg::FN_ROR;
			end
			c65_pkg::CMD_ADC: push_op.cls = c65_pkg::CLS_ADD;
			c65_pkg::CMD_SBC: begin
				// subtract as add of the complemented operand
				push_op.cls     = c65_pkg::CLS_ADD;
				push_op.operand = ~in_data.operand;
			end
			c65_pkg::CMD_CMP: begin
				push_op.cls     = c65_pkg::CLS_CMP;
				push_op.src_reg = c65_pkg::REG_A;
			end
			c65_pkg::CMD_CPX: begin
				push_op.cls     = c65_pkg::CLS_CMP;
				push_op.src_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_CPY: begin
				push_op.cls     = c65_pkg::CLS_CMP;
				push_op.src_reg = c65_pkg::REG_Y;
			end
			c65_pkg::CMD_LDA: begin
				push_op.cls     = c65_pkg::CLS_LOAD;
				push_op.dst_reg = c65_pkg::REG_A;
			end
			c65_pkg::CMD_LDX: begin
				push_op.cls     = c65_pkg::CLS_LOAD;
				push_op.dst_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_LDY: begin
				push_op.cls     = c65_pkg::CLS_LOAD;
				push_op.dst_reg = c65_pkg::REG_Y;
			end
			c65_pkg::CMD_STA: begin
				push_op.cls     = c65_pkg::CLS_STORE;
				push_op.src_reg = c65_pkg::REG_A;
			end
			c65_pkg::CMD_STX: begin
				push_op.cls     = c65_pkg::CLS_STORE;
				push_op.src_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_STY: begin
				push_op.cls     = c65_pkg::CLS_STORE;
				push_op.src_reg = c65_pkg::REG_Y;
			end
			c65_pkg::CMD_TAX: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_A;
				push_op.dst_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_TAY: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_A;
				push_op.dst_reg = c65_pkg::REG_Y;
			end
			c65_pkg::CMD_TSX: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_S;
				push_op.dst_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_TXA: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_X;
				push_op.dst_reg = c65_pkg::REG_A;
			end
			c65_pkg::CMD_TXS: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_X;
				push_op.dst_reg = c65_pkg::REG_S;
			end
			c65_pkg::CMD_TYA: begin
				push_op.cls     = c65_pkg::CLS_XFER;
				push_op.src_reg = c65_pkg::REG_Y;
				push_op.dst_reg = c65_pkg::REG_A;
			end
			c65_pkg::CMD_INC: begin
				push_op.cls = c65_pkg::CLS_STEPM;
				push_op.fn  = c65_pkg::FN_INC;
			end
			c65_pkg::CMD_DEC: begin
				push_op.cls = c65_pkg::CLS_STEPM;
				push_op.fn  = c65_pkg::FN_DEC;
			end
			c65_pkg::CMD_INX: begin
				push_op.cls     = c65_pkg::CLS_STEPR;
				push_op.fn      = c65_pkg::FN_INC;
				push_op.dst_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_INY: begin
				push_op.cls     = c65_pkg::CLS_STEPR;
				push_op.fn      = c65_pkg::FN_INC;
				push_op.dst_reg = c65_pkg::REG_Y;
			end
			c65_pkg::CMD_DEX: begin
				push_op.cls     = c65_pkg::CLS_STEPR;
				push_op.fn      = c65_pkg::FN_DEC;
				push_op.dst_reg = c65_pkg::REG_X;
			end
			c65_pkg::CMD_DEY: begin
				push_op.cls     = c65_pkg::CLS_STEPR;
				push_op.fn      = c65_pkg::FN_DEC;
				push_op.dst_reg = c65_pkg::REG_Y;
			end
			default: push_op.cls = c65_pkg::CLS_NOP;
		endcase
	end

endmodule

@@ rtl/c65_queue.sv @@
module c65_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  c65_pkg::dec_op_t push_op,
	output logic             full,
	output logic             head_valid,
	output c65_pkg::dec_op_t head_op,
	input  logic             pop
);

	c65_pkg::dec_op_t                  mem_q [c65_pkg::QUEUE_DEPTH];
	logic [c65_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [c65_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [c65_pkg::QCNT_W-1:0]        count_q;
	logic                              do_pop;

	assign full       = (count_q == c65_pkg::QCNT_W'(c65_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == c65_pkg::QPTR_W'(c65_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == c65_pkg::QPTR_W'(c65_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/c65_back.sv @@
module c65_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  c65_pkg::dec_op_t  head_op,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output c65_pkg::out_item_t out_data
);

	logic [7:0] a_q, x_q, y_q, s_q;
	logic       n_q, v_q, z_q, c_q;
	logic       out_valid_q;
	c65_pkg::out_item_t out_data_q;

	logic [7:0] a_n, x_n, y_n, s_n;
	logic       n_n, v_n, z_n, c_n;
	logic [7:0] wval, m, src_val, dst_val, sh_src, sh_res, nz_val;
	logic [7:0] dst_data, step_val;
	logic       wen, set_nz, dst_we, sh_c;
	logic [8:0] sum9, cmp9;

	assign m    = head_op.operand;
	assign pop  = head_valid && (!out_valid_q || out_ready);
	assign sum9 = {1'b0, a_q} + {1'b0, m} + {8'b0, c_q};
	assign cmp9 = {1'b0, src_val} - {1'b0, m};

	always_comb begin
		unique case (head_op.src_reg)
			c65_pkg::REG_A: src_val = a_q;
			c65_pkg::REG_X: src_val = x_q;
			c65_pkg::REG_Y: src_val = y_q;
			default:        src_val = s_q;
		endcase
		unique case (head_op.dst_reg)
			c65_pkg::REG_A: dst_val = a_q;
			c65_pkg::REG_X: dst_val = x_q;
			c65_pkg::REG_Y: dst_val = y_q;
			default:        dst_val = s_q;
		endcase
	end

	always_comb begin
		sh_src = head_op.to_acc ? a_q : m;
		unique case (head_op.fn)
			c65_pkg::FN_ASL: begin
				sh_res = {sh_src[6:0], 1'b0};
				sh_c   = sh_src[7];
			end
			c65_pkg::FN_LSR: begin
				sh_res = {1'b0, sh_src[7:1]};
				sh_c   = sh_src[0];
			end
			c65_pkg::FN_ROL: begin
				sh_res = {sh_src[6:0], c_q};
				sh_c   = sh_src[7];
			end
			default: begin
				sh_res = {c_q, sh_src[7:1]};
				sh_c   = sh_src[0];
			end
		endcase
	end

	always_comb begin
		step_val = (head_op.cls == c65_pkg::CLS_STEPM) ? m : dst_val;
		if (head_op.fn == c65_pkg::FN_DEC) begin
			step_val = step_val - 8'd1;
		end else begin
			step_val = step_val + 8'd1;
		end
	end

	always_comb begin
		a_n      = a_q;
		x_n      = x_q;
		y_n      = y_q;
		s_n      = s_q;
		n_n      = n_q;
		v_n      = v_q;
		z_n      = z_q;
		c_n      = c_q;
		wval     = 8'd0;
		wen      = 1'b0;
		set_nz   = 1'b0;
		nz_val   = 8'd0;
		dst_we   = 1'b0;
		dst_data = 8'd0;
		unique case (head_op.cls)
			c65_pkg::CLS_LOGIC: begin
				unique case (head_op.fn)
					c65_pkg::FN_OR:  a_n = a_q | m;
					c65_pkg::FN_AND: a_n = a_q & m;
					default:         a_n = a_q ^ m;
				endcase
				set_nz = 1'b1;
				nz_val = a_n;
			end
			c65_pkg::CLS_BIT: begin
				v_n = m[6];
				n_n = m[7];
				z_n = ((a_q & m) == 8'd0);
			end
			c65_pkg::CLS_SHIFT: begin
				c_n    = sh_c;
				set_nz = 1'b1;
				nz_val = sh_res;
				if (head_op.to_acc) begin
					a_n = sh_res;
				end else begin
					wval = sh_res;
					wen  = 1'b1;
				end
			end
			c65_pkg::CLS_ADD: begin
				a_n    = sum9[7:0];
				c_n    = sum9[8];
				v_n    = (a_q[7] ^ sum9[7]) & (m[7] ^ sum9[7]);
				set_nz = 1'b1;
				nz_val = sum9[7:0];
			end
			c65_pkg::CLS_CMP: begin
				c_n    = ~cmp9[8];
				set_nz = 1'b1;
				nz_val = cmp9[7:0];
			end
			c65_pkg::CLS_LOAD: begin
				dst_we   = 1'b1;
				dst_data = m;
				set_nz   = 1'b1;
				nz_val   = m;
			end
			c65_pkg::CLS_STORE: begin
				wval = src_val;
				wen  = 1'b1;
			end
			c65_pkg::CLS_XFER: begin
				dst_we   = 1'b1;
				dst_data = src_val;
				// TXS leaves the flags alone
				set_nz   = (head_op.dst_reg != c65_pkg::REG_S);
				nz_val   = src_val;
			end
			c65_pkg::CLS_STEPM: begin
				wval   = step_val;
				wen    = 1'b1;
				set_nz = 1'b1;
				nz_val = step_val;
			end
			c65_pkg::CLS_STEPR: begin
				dst_we   = 1'b1;
				dst_data = step_val;
				set_nz   = 1'b1;
				nz_val   = step_val;
			end
			default: begin
			end
		endcase
		if (dst_we) begin
			unique case (head_op.dst_reg)
				c65_pkg::REG_A: a_n = dst_data;
				c65_pkg::REG_X: x_n = dst_data;
				c65_pkg::REG_Y: y_n = dst_data;
				default:        s_n = dst_data;
			endcase
		end
		if (set_nz) begin
			z_n = (nz_val == 8'd0);
			n_n = nz_val[7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= 8'd0;
			x_q         <= 8'd0;
			y_q         <= 8'd0;
			s_q         <= c65_pkg::SP_RESET;
			n_q         <= 1'b0;
			v_q         <= 1'b0;
			z_q         <= 1'b0;
			c_q         <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				a_q <= a_n;
				x_q <= x_n;
				y_q <= y_n;
				s_q <= s_n;
				n_q <= n_n;
				v_q <= v_n;
				z_q <= z_n;
				c_q <= c_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.write_value  <= wval;
			out_data_q.write_enable <= wen;
			out_data_q.acc_value    <= a_n;
			out_data_q.x_value      <= x_n;
			out_data_q.y_value      <= y_n;
			out_data_q.stack_value  <= s_n;
			out_data_q.flags_nvzc   <= {n_n, v_n, z_n, c_n};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/cpu6502_alu_register_execute_core.sv @@
// Flow: an item transferred in is written into the decode queue at that same edge, then executed
// from the queue head into the output register once that register is free or being taken,
// and the result shows on the output from that register.
// Throughput: one item per cycle while each result is taken by out_ready; the execute stage's register
// file and flags feed the next operation directly.
// Reset: arst_n clears A, X, Y and the flags, loads S with 0xFD and empties the queue.
module cpu6502_alu_register_execute_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  c65_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output c65_pkg::out_item_t out_data
);

	logic             push_valid;
	c65_pkg::dec_op_t push_op;
	logic             queue_full;
	logic             head_valid;
	c65_pkg::dec_op_t head_op;
	logic             pop;

	c65_front u_front (
		.in_data    (in_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	c65_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop)
	);

	c65_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ rtl/c65_checker.sv @@
module c65_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input c65_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input c65_pkg::out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_wval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_enable |-> out_data.write_value == 8'd0)
		else $error("write value not zero without write enable");

	// an input taken while the output is empty is followed by a valid output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("result did not appear in time");

	// the queue fills only behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind cpu6502_alu_register_execute_core c65_checker u_c65_checker (.*);

@@ dv/cpu6502_alu_register_execute_core_tb.sv @@
`timescale 1ns / 100ps

module cpu6502_alu_register_execute_core_tb;

	localparam logic [4:0]  CMD_UNUSED = 5'd31;
	localparam int unsigned RANDOM_OPS = 1450;
	localparam int unsigned MAX_IDLE   = 17;

	typedef struct {
		c65_pkg::in_item_t op;
		int unsigned       idle;
		bit                drain;
	} stim_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	c65_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	c65_pkg::out_item_t out_data;

	logic [7:0] edge_bytes [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};

	stim_t              op_queue[$];
	c65_pkg::out_item_t results_due[$];
	c65_pkg::out_item_t oldest_due;

	// predicted architectural state
	logic [7:0] acc_q = 8'h00;
	logic [7:0] x_q   = 8'h00;
	logic [7:0] y_q   = 8'h00;
	logic [7:0] sp_q  = c65_pkg::SP_RESET;
	logic       n_q   = 1'b0;
	logic       v_q   = 1'b0;
	logic       z_q   = 1'b0;
	logic       c_q   = 1'b0;

	bit          in_taken    = 1'b0;
	bit          out_taken   = 1'b0;
	bit          hold_off    = 1'b0;
	bit          sink_calm   = 1'b0;
	int unsigned send_wait   = 0;
	int unsigned sink_wait   = 0;
	int unsigned ops_taken   = 0;
	int unsigned results_seen = 0;
	int unsigned mem_writes  = 0;
	int unsigned in_stalls   = 0;
	int unsigned err_count   = 0;
	logic [31:0] cmd_seen    = '0;

	cpu6502_alu_register_execute_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR t=%0t result %0d %s: got %0h, expected %0h",
			$time, results_seen, what, got, want);
		err_count++;
	endtask

	function automatic void update_nz(logic [7:0] val);
		z_q = (val == 8'h00);
		n_q = val[7];
	endfunction

	function automatic void compare_to(logic [7:0] lhs, logic [7:0] m);
		logic [7:0] diff;
		diff = lhs - m;
		c_q = (lhs >= m);
		update_nz(diff);
	endfunction

	function automatic c65_pkg::out_item_t run_6502_op(c65_pkg::in_item_t op);
		logic [7:0]         m;
		logic [7:0]         src;
		logic [7:0]         res;
		logic [8:0]         sum;
		c65_pkg::out_item_t r;
		m = op.operand;
		r = '0;
		case (op.command)
			c65_pkg::CMD_ORA: begin acc_q = acc_q | m; update_nz(acc_q); end
			c65_pkg::CMD_AND: begin acc_q = acc_q & m; update_nz(acc_q); end
			c65_pkg::CMD_EOR: begin acc_q = acc_q ^ m; update_nz(acc_q); end
			c65_pkg::CMD_BIT: begin
				v_q = m[6];
				n_q = m[7];
				z_q = ((acc_q & m) == 8'h00);
			end
			c65_pkg::CMD_ASL, c65_pkg::CMD_LSR, c65_pkg::CMD_ROL, c65_pkg::CMD_ROR: begin
				src = op.target_is_accumulator ? acc_q : m;
				case (op.command)
					c65_pkg::CMD_ASL: res = {src[6:0], 1'b0};
					c65_pkg::CMD_LSR: res = {1'b0, src[7:1]};
					c65_pkg::CMD_ROL: res = {src[6:0], c_q};
					default:          res = {c_q, src[7:1]};
				endcase
				c_q = (op.command == c65_pkg::CMD_ASL || op.command == c65_pkg::CMD_ROL)
					? src[7] : src[0];
				update_nz(res);
				if (op.target_is_accumulator) begin
					acc_q = res;
				end else begin
					r.write_value  = res;
					r.write_enable = 1'b1;
				end
			end
			c65_pkg::CMD_ADC, c65_pkg::CMD_SBC: begin
				// subtract is add of the inverted operand, carry acting as not-borrow
				src = (op.command == c65_pkg::CMD_SBC) ? ~m : m;
				sum = {1'b0, acc_q} + {1'b0, src} + {8'h00, c_q};
				res = sum[7:0];
				v_q = (acc_q[7] ^ res[7]) & (src[7] ^ res[7]);
				c_q = sum[8];
				acc_q = res;
				update_nz(res);
			end
			c65_pkg::CMD_CMP: compare_to(acc_q, m);
			c65_pkg::CMD_CPX: compare_to(x_q, m);
			c65_pkg::CMD_CPY: compare_to(y_q, m);
			c65_pkg::CMD_LDA: begin acc_q = m; update_nz(m); end
			c65_pkg::CMD_LDX: begin x_q = m; update_nz(m); end
			c65_pkg::CMD_LDY: begin y_q = m; update_nz(m); end
			c65_pkg::CMD_STA: begin r.write_value = acc_q; r.write_enable = 1'b1; end
			c65_pkg::CMD_STX: begin r.write_value = x_q; r.write_enable = 1'b1; end
			c65_pkg::CMD_STY: begin r.write_value = y_q; r.write_enable = 1'b1; end
			c65_pkg::CMD_TAX: begin x_q = acc_q; update_nz(x_q); end
			c65_pkg::CMD_TAY: begin y_q = acc_q; update_nz(y_q); end
			c65_pkg::CMD_TSX: begin x_q = sp_q; update_nz(x_q); end
			c65_pkg::CMD_TXA: begin acc_q = x_q; update_nz(acc_q); end
			c65_pkg::CMD_TXS: sp_q = x_q;
			c65_pkg::CMD_TYA: begin acc_q = y_q; update_nz(acc_q); end
			c65_pkg::CMD_INC: begin
				res = m + 8'd1;
				r.write_value  = res;
				r.write_enable = 1'b1;
				update_nz(res);
			end
			c65_pkg::CMD_DEC: begin
				res = m - 8'd1;
				r.write_value  = res;
				r.write_enable = 1'b1;
				update_nz(res);
			end
			c65_pkg::CMD_INX: begin x_q = x_q + 8'd1; update_nz(x_q); end
			c65_pkg::CMD_INY: begin y_q = y_q + 8'd1; update_nz(y_q); end
			c65_pkg::CMD_DEX: begin x_q = x_q - 8'd1; update_nz(x_q); end
			c65_pkg::CMD_DEY: begin y_q = y_q - 8'd1; update_nz(y_q); end
			default: ; // unused code leaves state alone
		endcase
		r.acc_value   = acc_q;
		r.x_value     = x_q;
		r.y_value     = y_q;
		r.stack_value = sp_q;
		r.flags_nvzc  = {n_q, v_q, z_q, c_q};
		return r;
	endfunction

	function automatic void add_op(logic [4:0] cmd, logic [7:0] operand, logic to_acc,
			int unsigned idle, bit drain);
		stim_t s;
		s.op.command               = cmd;
		s.op.operand               = operand;
		s.op.target_is_accumulator = to_acc;
		s.idle                     = idle;
		s.drain                    = drain;
		op_queue.push_back(s);
	endfunction

	// sender: offer the next operation once the current one has transferred and its wait is over
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (op_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_wait < op_queue[0].idle ||
					(op_queue[0].drain && results_due.size() != 0)) begin
				send_wait++;
				in_valid <= 1'b0;
			end else begin
				in_data   <= op_queue[0].op;
				in_valid  <= 1'b1;
				send_wait = 0;
				op_queue.delete(0);
			end
		end
	end

	// receiver: draw a stall after every transfer out
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 39) == 0) begin
				sink_calm = !sink_calm;
			end
			sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
		end
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		in_taken  = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		if (arst_n && in_valid && !in_ready) begin
			in_stalls++;
		end
		if (out_taken) begin
			if (results_due.size() == 0) begin
				report_error("result with nothing expected", 64'(out_data), 64'd0);
			end else begin
				oldest_due = results_due.pop_front();
				if (out_data.write_value !== oldest_due.write_value)
					report_error("write_value", 64'(out_data.write_value),
						64'(oldest_due.write_value));
				if (out_data.write_enable !== oldest_due.write_enable)
					report_error("write_enable", 64'(out_data.write_enable),
						64'(oldest_due.write_enable));
				if (out_data.acc_value !== oldest_due.acc_value)
					report_error("acc_value", 64'(out_data.acc_value),
						64'(oldest_due.acc_value));
				if (out_data.x_value !== oldest_due.x_value)
					report_error("x_value", 64'(out_data.x_value),
						64'(oldest_due.x_value));
				if (out_data.y_value !== oldest_due.y_value)
					report_error("y_value", 64'(out_data.y_value),
						64'(oldest_due.y_value));
				if (out_data.stack_value !== oldest_due.stack_value)
					report_error("stack_value", 64'(out_data.stack_value),
						64'(oldest_due.stack_value));
				if (out_data.flags_nvzc !== oldest_due.flags_nvzc)
					report_error("flags_nvzc", 64'(out_data.flags_nvzc),
						64'(oldest_due.flags_nvzc));
				if (oldest_due.write_enable) begin
					mem_writes++;
				end
			end
			results_seen++;
		end
		if (in_taken) begin
			results_due.push_back(run_6502_op(in_data));
			cmd_seen[in_data.command] = 1'b1;
			ops_taken++;
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin
		while (ops_taken < 300) @(posedge clk);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		bit          send_calm;
		int unsigned idle;
		logic [7:0]  operand;
		send_calm = 1'b0;

		// every command code with edge operands; odd codes set the accumulator selector
		for (int c = 0; c < 32; c++) begin
			add_op(5'(c), edge_bytes[c % 4], 1'(c % 2), $urandom_range(0, MAX_IDLE), 1'b0);
		end
		add_op(c65_pkg::CMD_LDA, 8'h7F, 1'b0, 0, 1'b0);
		add_op(c65_pkg::CMD_ADC, 8'h01, 1'b0, 0, 1'b0); // signed overflow into bit 7
		add_op(c65_pkg::CMD_INC, 8'hFF, 1'b1, 0, 1'b0); // wrap to zero, selector ignored
		add_op(CMD_UNUSED, 8'hFF, 1'b0, 0, 1'b0);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 50 == 0) begin
				send_calm = ($urandom_range(0, 3) == 0);
			end
			// keep the sender busy around the receiver hold-off
			idle = (send_calm || (i >= 260 && i < 420)) ? 0 : $urandom_range(0, MAX_IDLE);
			operand = ($urandom_range(0, 3) == 0) ? edge_bytes[$urandom_range(0, 3)]
				: 8'($urandom);
			add_op(5'($urandom_range(0, 31)), operand, 1'($urandom), idle, i % 250 == 125);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d operations over %0d of 32 command codes, %0d results checked",
			ops_taken, $countones(cmd_seen), results_seen);
		$display("Memory writes %0d, input back-pressure cycles %0d, mismatches %0d",
			mem_writes, in_stalls, err_count);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
